@@ hw/rtl/bleadv_pkg.sv @@
// package for the advertising data name and flags parser
// holds structure type codes, limits, phase and status codes and the event types
// no dependencies
package bleadv_pkg;

    localparam int MAX_ADV_LEN  = 31;
    localparam int MAX_NAME_LEN = 63;

    localparam logic [7:0] TYPE_FLAGS         = 8'h01;
    localparam logic [7:0] TYPE_NAME_SHORT    = 8'h08;
    localparam logic [7:0] TYPE_NAME_COMPLETE = 8'h09;

    localparam logic [7:0] MODE_LIMITED_BIT = 8'h01;
    localparam logic [7:0] MODE_GENERAL_BIT = 8'h02;

    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_LIMITED = 2'd1;
    localparam logic [1:0] MODE_GENERAL = 2'd2;

    localparam logic [2:0] REG_DISCOVERY_MODE = 3'd0;

    typedef enum logic [1:0] {
        PH_LENGTH      = 2'd0,
        PH_TYPE        = 2'd1,
        PH_VALUE       = 2'd2,
        PH_FLAGS_VALUE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERRUN   = 2'd1,
        ST_NAME_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic       found;
        logic [4:0] length;
        logic       flags_found;
        logic [7:0] flags_value;
        logic       accepted;
        t_status    status;
        logic       device;
    } t_verdict;

    typedef struct packed {
        logic       has_name;
        logic [7:0] name_byte;
        logic       name_last;
        logic       has_verdict;
        t_verdict   verdict;
    } t_evt;

endpackage

@@ hw/rtl/bleadv_front.sv @@
// front end: accepts advertising bytes, walks length-type-value structures
// and builds one event per transaction that causes results; uses bleadv_pkg
module bleadv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mode,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ad_byte,
    input  logic                i_has_byte,
    input  logic [4:0]          i_report_length,
    input  logic                i_report_last,
    input  logic                i_full,
    output logic                o_push,
    output bleadv_pkg::t_evt    o_evt
);

    logic [4:0]          r_pos,         n_pos;
    logic [7:0]          r_rem,         n_rem;
    bleadv_pkg::t_phase  r_phase,       n_phase;
    logic                r_stopped,     n_stopped;
    logic                r_name_active, n_name_active;
    logic                r_name_done,   n_name_done;
    logic [5:0]          r_name_count,  n_name_count;
    logic                r_flags_seen,  n_flags_seen;
    logic [7:0]          r_flags_byte,  n_flags_byte;
    bleadv_pkg::t_status r_status,      n_status;

    logic                accept;
    logic [4:0]          limit;
    logic [7:0]          vlen;
    logic                flags_first;
    logic                nm_valid;
    logic                nm_last;
    bleadv_pkg::t_status v_status;
    logic                v_accepted;
    logic                v_found;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign limit   = ({4'b0, i_report_length} < 9'(bleadv_pkg::MAX_ADV_LEN))
                   ? i_report_length : 5'(bleadv_pkg::MAX_ADV_LEN);
    assign vlen    = r_rem - 8'd1;

    // walk of one byte
    always_comb begin
        n_pos         = r_pos;
        n_rem         = r_rem;
        n_phase       = r_phase;
        n_stopped     = r_stopped;
        n_name_active = r_name_active;
        n_name_done   = r_name_done;
        n_name_count  = r_name_count;
        n_flags_seen  = r_flags_seen;
        n_flags_byte  = r_flags_byte;
        n_status      = r_status;
        flags_first   = 1'b0;
        nm_valid      = 1'b0;
        nm_last       = 1'b0;
        if (i_has_byte) begin
            if (!r_stopped && (r_pos < limit)) begin
                unique case (r_phase)
                    bleadv_pkg::PH_LENGTH: begin
                        if (i_ad_byte == 8'd0) begin
                            n_stopped = 1'b1;
                        end else if (({4'b0, r_pos} + 9'd1 + {1'b0, i_ad_byte})
                                     > {4'b0, limit}) begin
                            if (r_status == bleadv_pkg::ST_OK) begin
                                n_status = bleadv_pkg::ST_OVERRUN;
                            end
                            n_stopped = 1'b1;
                        end else begin
                            n_rem   = i_ad_byte;
                            n_phase = bleadv_pkg::PH_TYPE;
                        end
                    end
                    bleadv_pkg::PH_TYPE: begin
                        n_rem = vlen;
                        if ((i_ad_byte == bleadv_pkg::TYPE_NAME_SHORT ||
                             i_ad_byte == bleadv_pkg::TYPE_NAME_COMPLETE) && !r_name_done) begin
                            n_name_done = 1'b1;
                            if ({1'b0, vlen} > 9'(bleadv_pkg::MAX_NAME_LEN)) begin
                                if (r_status == bleadv_pkg::ST_OK) begin
                                    n_status = bleadv_pkg::ST_NAME_LONG;
                                end
                            end else if (vlen != 8'd0) begin
                                n_name_active = 1'b1;
                            end
                        end
                        if (i_ad_byte == bleadv_pkg::TYPE_FLAGS && !r_flags_seen) begin
                            if (vlen == 8'd0) begin
                                n_flags_seen = 1'b1;
                                n_flags_byte = 8'd0;
                            end else begin
                                flags_first = 1'b1;
                            end
                        end
                        if (vlen == 8'd0) begin
                            n_phase = bleadv_pkg::PH_LENGTH;
                        end else if (flags_first) begin
                            n_phase = bleadv_pkg::PH_FLAGS_VALUE;
                        end else begin
                            n_phase = bleadv_pkg::PH_VALUE;
                        end
                    end
                    default: begin
                        if (r_phase == bleadv_pkg::PH_FLAGS_VALUE) begin
                            n_flags_byte = i_ad_byte;
                            n_flags_seen = 1'b1;
                        end
                        if (r_name_active) begin
                            nm_valid     = 1'b1;
                            nm_last      = (r_rem == 8'd1);
                            n_name_count = r_name_count + 6'd1;
                            if (nm_last) begin
                                n_name_active = 1'b0;
                            end
                        end
                        n_rem   = vlen;
                        n_phase = (vlen == 8'd0) ? bleadv_pkg::PH_LENGTH
                                                 : bleadv_pkg::PH_VALUE;
                    end
                endcase
            end
            if (r_pos != 5'd31) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    // verdict from the state after this byte
    always_comb begin
        v_status = n_status;
        if (!n_stopped && (n_phase != bleadv_pkg::PH_LENGTH) &&
            (v_status == bleadv_pkg::ST_OK)) begin
            v_status = bleadv_pkg::ST_OVERRUN;
        end
        unique case (i_mode)
            bleadv_pkg::MODE_ALL:     v_accepted = 1'b1;
            bleadv_pkg::MODE_LIMITED: v_accepted = n_flags_seen &&
                ((n_flags_byte & bleadv_pkg::MODE_LIMITED_BIT) != 8'd0);
            bleadv_pkg::MODE_GENERAL: v_accepted = n_flags_seen &&
                ((n_flags_byte & (bleadv_pkg::MODE_LIMITED_BIT |
                                  bleadv_pkg::MODE_GENERAL_BIT)) != 8'd0);
            default:                  v_accepted = 1'b0;
        endcase
        v_found = n_name_done && !n_name_active && (v_status != bleadv_pkg::ST_NAME_LONG);
    end

    always_comb begin
        o_push                    = accept && (nm_valid || i_report_last);
        o_evt.has_name            = nm_valid;
        o_evt.name_byte           = i_ad_byte;
        o_evt.name_last           = nm_last;
        o_evt.has_verdict         = i_report_last;
        o_evt.verdict.found       = v_found;
        o_evt.verdict.length      = n_name_count[4:0];
        o_evt.verdict.flags_found = n_flags_seen;
        o_evt.verdict.flags_value = n_flags_byte;
        o_evt.verdict.accepted    = v_accepted;
        o_evt.verdict.status      = v_status;
        o_evt.verdict.device      = v_accepted && v_found && (n_name_count[4:0] != 5'd0);
    end

    // the last transaction of a report clears the per-report state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= 5'd0;
            r_rem         <= 8'd0;
            r_phase       <= bleadv_pkg::PH_LENGTH;
            r_stopped     <= 1'b0;
            r_name_active <= 1'b0;
            r_name_done   <= 1'b0;
            r_name_count  <= 6'd0;
            r_flags_seen  <= 1'b0;
            r_flags_byte  <= 8'd0;
            r_status      <= bleadv_pkg::ST_OK;
        end else if (accept) begin
            if (i_report_last) begin
                r_pos         <= 5'd0;
                r_rem         <= 8'd0;
                r_phase       <= bleadv_pkg::PH_LENGTH;
                r_stopped     <= 1'b0;
                r_name_active <= 1'b0;
                r_name_done   <= 1'b0;
                r_name_count  <= 6'd0;
                r_flags_seen  <= 1'b0;
                r_flags_byte  <= 8'd0;
                r_status      <= bleadv_pkg::ST_OK;
            end else begin
                r_pos         <= n_pos;
                r_rem         <= n_rem;
                r_phase       <= n_phase;
                r_stopped     <= n_stopped;
                r_name_active <= n_name_active;
                r_name_done   <= n_name_done;
                r_name_count  <= n_name_count;
                r_flags_seen  <= n_flags_seen;
                r_flags_byte  <= n_flags_byte;
                r_status      <= n_status;
            end
        end
    end

endmodule

@@ hw/rtl/bleadv_queue.sv @@
// event queue between front end and back end
// circular buffer of bleadv_pkg::t_evt entries
module bleadv_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bleadv_pkg::t_evt i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output bleadv_pkg::t_evt o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bleadv_pkg::t_evt r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/bleadv_back.sv @@
// back end: splits each queued event into name byte and verdict results
// and holds them in the output register; uses bleadv_pkg
module bleadv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bleadv_pkg::t_evt i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_name_byte,
    output logic             o_name_last,
    output logic             o_name_found,
    output logic [4:0]       o_name_length,
    output logic             o_flags_found,
    output logic [7:0]       o_flags_value,
    output logic             o_report_accepted,
    output logic [1:0]       o_parse_status,
    output logic             o_device_found
);

    logic                r_valid, n_valid;
    logic                r_half,  n_half;
    logic                r_kind;
    logic [7:0]          r_name_byte;
    logic                r_name_last;
    bleadv_pkg::t_verdict r_verdict;

    logic                load;
    logic                emit_name;

    assign load      = !i_empty && (!r_valid || !i_stall);
    assign emit_name = i_head.has_name && !r_half;
    assign o_pop     = load && !(emit_name && i_head.has_verdict);

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        if (load) begin
            n_valid = 1'b1;
            n_half  = emit_name && i_head.has_verdict;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_name) begin
                r_kind      <= 1'b0;
                r_name_byte <= i_head.name_byte;
                r_name_last <= i_head.name_last;
                r_verdict   <= '0;
            end else begin
                r_kind      <= 1'b1;
                r_name_byte <= 8'd0;
                r_name_last <= 1'b0;
                r_verdict   <= i_head.verdict;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_result_kind     = r_kind;
    assign o_name_byte       = r_name_byte;
    assign o_name_last       = r_name_last;
    assign o_name_found      = r_verdict.found;
    assign o_name_length     = r_verdict.length;
    assign o_flags_found     = r_verdict.flags_found;
    assign o_flags_value     = r_verdict.flags_value;
    assign o_report_accepted = r_verdict.accepted;
    assign o_parse_status    = r_verdict.status;
    assign o_device_found    = r_verdict.device;

endmodule

@@ hw/rtl/ble_adv_data_name_flags_parser.sv @@
// advertising data name and flags parser, top level with discovery mode register
// an input transaction goes into the queue and its first result into the output register; a
// byte that ends a name on the last item gives two results, the name byte before the verdict
// throughput: one input transaction per cycle unless o_stall, one result per cycle unless i_stall
// reset: synchronous active low, clears walk state, queue, output valid and mode
// depends on bleadv_pkg, bleadv_front, bleadv_queue, bleadv_back
module ble_adv_data_name_flags_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ad_byte,
    input  logic        i_has_byte,
    input  logic [4:0]  i_report_length,
    input  logic        i_report_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_name_byte,
    output logic        o_name_last,
    output logic        o_name_found,
    output logic [4:0]  o_name_length,
    output logic        o_flags_found,
    output logic [7:0]  o_flags_value,
    output logic        o_report_accepted,
    output logic [1:0]  o_parse_status,
    output logic        o_device_found
);

    logic [1:0]       r_mode;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    bleadv_pkg::t_evt q_push_data;
    bleadv_pkg::t_evt q_head;

    assign pready = 1'b1;
    assign prdata = (paddr == bleadv_pkg::REG_DISCOVERY_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bleadv_pkg::MODE_ALL;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_mode <= pwdata[1:0];
        end
    end

    bleadv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (r_mode),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ad_byte       (i_ad_byte),
        .i_has_byte      (i_has_byte),
        .i_report_length (i_report_length),
        .i_report_last   (i_report_last),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_evt           (q_push_data)
    );

    bleadv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    bleadv_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (q_head),
        .i_empty           (q_empty),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_name_byte       (o_name_byte),
        .o_name_last       (o_name_last),
        .o_name_found      (o_name_found),
        .o_name_length     (o_name_length),
        .o_flags_found     (o_flags_found),
        .o_flags_value     (o_flags_value),
        .o_report_accepted (o_report_accepted),
        .o_parse_status    (o_parse_status),
        .o_device_found    (o_device_found)
    );

endmodule

@@ bench/tb.sv @@
// testbench for ble_adv_data_name_flags_parser: advertising reports in, name bytes and verdicts out
// predicts every result in-bench and checks it against the dut, with random idling on both sides
// depends on bleadv_pkg and the parser rtl
`timescale 1ns / 100ps

module tb;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam logic [2:0] MODE_ADDR      = 3'(bleadv_pkg::REG_DISCOVERY_MODE * 4);

    typedef logic [7:0] t_ad_data[$];

    typedef struct packed {
        logic       kind;
        logic [7:0] nbyte;
        logic       nlast;
        logic       found;
        logic [4:0] nlen;
        logic       flags_found;
        logic [7:0] flags_value;
        logic       accepted;
        logic [1:0] status;
        logic       device;
    } t_parse_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ad_byte;
    logic        i_has_byte;
    logic [4:0]  i_report_length;
    logic        i_report_last;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_name_byte;
    logic        o_name_last;
    logic        o_name_found;
    logic [4:0]  o_name_length;
    logic        o_flags_found;
    logic [7:0]  o_flags_value;
    logic        o_report_accepted;
    logic [1:0]  o_parse_status;
    logic        o_device_found;

    // predictor state
    logic [1:0]          disc_mode = bleadv_pkg::MODE_ALL;
    logic [4:0]          pos;
    logic [7:0]          remaining;
    bleadv_pkg::t_phase  phase;
    logic                walk_stopped;
    logic                name_on;
    logic                name_seen;
    logic [5:0]          name_cnt;
    logic                flags_seen;
    logic [7:0]          flags_val;
    bleadv_pkg::t_status status;

    t_parse_out name_and_verdict_q[$];
    int         fail_count  = 0;
    int         items_sent  = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    bit         quiet       = 1'b0;

    ble_adv_data_name_flags_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ad_byte        (i_ad_byte),
        .i_has_byte       (i_has_byte),
        .i_report_length  (i_report_length),
        .i_report_last    (i_report_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_name_byte      (o_name_byte),
        .o_name_last      (o_name_last),
        .o_name_found     (o_name_found),
        .o_name_length    (o_name_length),
        .o_flags_found    (o_flags_found),
        .o_flags_value    (o_flags_value),
        .o_report_accepted(o_report_accepted),
        .o_parse_status   (o_parse_status),
        .o_device_found   (o_device_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string fname, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", fname, got, want));
    endtask

    function automatic int gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    task automatic clear_report();
        pos          = '0;
        remaining    = '0;
        phase        = bleadv_pkg::PH_LENGTH;
        walk_stopped = 1'b0;
        name_on      = 1'b0;
        name_seen    = 1'b0;
        name_cnt     = '0;
        flags_seen   = 1'b0;
        flags_val    = '0;
        status       = bleadv_pkg::ST_OK;
    endtask

    task automatic raise_status(input bleadv_pkg::t_status code);
        if (status == bleadv_pkg::ST_OK) status = code;
    endtask

    task automatic parse_ad_item(input logic [7:0] b, input logic has, input logic [4:0] rlen,
                                 input logic last);
        int         lim;
        int         vlen;
        bit         flags_first;
        bit         accept;
        bit         found;
        t_parse_out r;
        lim = (int'(rlen) < bleadv_pkg::MAX_ADV_LEN) ? int'(rlen) : bleadv_pkg::MAX_ADV_LEN;
        if (has) begin
            if (!walk_stopped && int'(pos) < lim) begin
                case (phase)
                    bleadv_pkg::PH_LENGTH: begin
                        if (b == 8'h00) begin
                            walk_stopped = 1'b1;
                        end else if (int'(pos) + 1 + int'(b) > lim) begin
                            raise_status(bleadv_pkg::ST_OVERRUN);
                            walk_stopped = 1'b1;
                        end else begin
                            remaining = b;
                            phase     = bleadv_pkg::PH_TYPE;
                        end
                    end
                    bleadv_pkg::PH_TYPE: begin
                        flags_first = 1'b0;
                        remaining   = remaining - 8'd1;
                        vlen        = int'(remaining);
                        if ((b == bleadv_pkg::TYPE_NAME_SHORT ||
                             b == bleadv_pkg::TYPE_NAME_COMPLETE) && !name_seen) begin
                            name_seen = 1'b1;
                            if (vlen > bleadv_pkg::MAX_NAME_LEN)
                                raise_status(bleadv_pkg::ST_NAME_LONG);
                            else if (vlen > 0) name_on = 1'b1;
                        end
                        if (b == bleadv_pkg::TYPE_FLAGS && !flags_seen) begin
                            if (vlen == 0) begin
                                flags_seen = 1'b1;
                                flags_val  = '0;
                            end else begin
                                flags_first = 1'b1;
                            end
                        end
                        if (vlen == 0) phase = bleadv_pkg::PH_LENGTH;
                        else if (flags_first) phase = bleadv_pkg::PH_FLAGS_VALUE;
                        else phase = bleadv_pkg::PH_VALUE;
                    end
                    default: begin
                        if (phase == bleadv_pkg::PH_FLAGS_VALUE) begin
                            flags_val  = b;
                            flags_seen = 1'b1;
                        end
                        if (name_on) begin
                            r       = '0;
                            r.nbyte = b;
                            r.nlast = (remaining == 8'd1);
                            name_and_verdict_q.insert(name_and_verdict_q.size(), r);
                            name_cnt = name_cnt + 6'd1;
                            if (remaining == 8'd1) name_on = 1'b0;
                        end
                        remaining = remaining - 8'd1;
                        if (remaining == 8'd0) phase = bleadv_pkg::PH_LENGTH;
                        else phase = bleadv_pkg::PH_VALUE;
                    end
                endcase
            end
            if (pos < 5'd31) pos = pos + 5'd1;
        end
        if (last) begin
            if (!walk_stopped && phase != bleadv_pkg::PH_LENGTH)
                raise_status(bleadv_pkg::ST_OVERRUN);
            case (disc_mode)
                bleadv_pkg::MODE_ALL:     accept = 1'b1;
                bleadv_pkg::MODE_LIMITED: accept = flags_seen &&
                    (flags_val & bleadv_pkg::MODE_LIMITED_BIT) != 0;
                bleadv_pkg::MODE_GENERAL: accept = flags_seen &&
                    (flags_val & (bleadv_pkg::MODE_LIMITED_BIT |
                                  bleadv_pkg::MODE_GENERAL_BIT)) != 0;
                default:                  accept = 1'b0;
            endcase
            found         = name_seen && !name_on && status != bleadv_pkg::ST_NAME_LONG;
            r             = '0;
            r.kind        = 1'b1;
            r.found       = found;
            r.nlen        = name_cnt[4:0];
            r.flags_found = flags_seen;
            r.flags_value = flags_val;
            r.accepted    = accept;
            r.status      = status;
            r.device      = accept && found && name_cnt[4:0] != 5'd0;
            name_and_verdict_q.insert(name_and_verdict_q.size(), r);
            clear_report();
        end
    endtask

    task automatic send_ad_item(input logic [7:0] b, input logic has, input logic [4:0] rlen,
                                input logic last);
        int gap;
        gap = (!quiet && $urandom_range(99) < 25) ? gap_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_ad_byte       <= b;
        i_has_byte      <= has;
        i_report_length <= rlen;
        i_report_last   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_ad_item(b, has, rlen, last);
        if (has || last) items_sent++;
    endtask

    task automatic send_report(input t_ad_data d, input logic [4:0] rlen, input bit close_empty,
                               input bit jitter);
        int i;
        for (i = 0; i < d.size(); i++) begin
            if (!quiet && $urandom_range(49) == 0)
                send_ad_item(8'($urandom_range(255)), 1'b0, rlen, 1'b0);
            send_ad_item(d[i], 1'b1, jitter ? 5'($urandom_range(31)) : rlen,
                         (i == d.size() - 1) && !close_empty);
        end
        if (close_empty || d.size() == 0)
            send_ad_item(8'($urandom_range(255)), 1'b0, rlen, 1'b1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (name_and_verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {30'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        disc_mode = m;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {30'd0, m})
            report_mismatch($sformatf("discovery_mode read 0x%0h want 0x%0h", prdata, m));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_report();
        t_ad_data d;
        d = {};
        send_report(d, 5'd0, 1'b1, 1'b0);
    endtask

    task automatic test_flags_then_name();
        t_ad_data d;
        // name ends on the last byte, so two results for one transaction
        d = {8'h02, bleadv_pkg::TYPE_FLAGS, 8'hFF, 8'h05, bleadv_pkg::TYPE_NAME_COMPLETE,
             8'h00, 8'h41, 8'hFF, 8'h80};
        send_report(d, 5'd9, 1'b0, 1'b0);
    endtask

    task automatic test_walk_stops();
        t_ad_data d;
        d = {8'h00, 8'hFF};
        send_report(d, 5'd31, 1'b0, 1'b0);
        d = {8'hFF};
        send_report(d, 5'd1, 1'b0, 1'b0);
        d = {8'h05};
        send_report(d, 5'd0, 1'b0, 1'b0);
    endtask

    task automatic test_empty_fields();
        t_ad_data d;
        d = {8'h01, bleadv_pkg::TYPE_NAME_SHORT, 8'h01, bleadv_pkg::TYPE_FLAGS};
        send_report(d, 5'd4, 1'b0, 1'b0);
    endtask

    task automatic test_truncated_report();
        t_ad_data d;
        d = {8'h03, bleadv_pkg::TYPE_NAME_SHORT, 8'h78};
        send_report(d, 5'd5, 1'b0, 1'b0);
    endtask

    task automatic test_bytes_past_report();
        t_ad_data d;
        d = {8'h02, bleadv_pkg::TYPE_FLAGS, 8'h05, bleadv_pkg::TYPE_NAME_COMPLETE};
        send_report(d, 5'd3, 1'b1, 1'b0);
    endtask

    task automatic test_discovery_modes();
        t_ad_data   d;
        logic [1:0] modes[4];
        int         m;
        int         f;
        modes = '{bleadv_pkg::MODE_LIMITED, bleadv_pkg::MODE_GENERAL, MODE_UNUSED,
                  bleadv_pkg::MODE_ALL};
        for (m = 0; m < 4; m++) begin
            write_mode(modes[m]);
            for (f = 0; f < 6; f++) begin
                if (f == 5)
                    d = {8'h03, bleadv_pkg::TYPE_NAME_COMPLETE, 8'h6F, 8'h6B};
                else
                    d = {8'h02, bleadv_pkg::TYPE_FLAGS,
                         (f == 4) ? 8'($urandom_range(255)) : 8'(f),
                         8'h03, bleadv_pkg::TYPE_NAME_COMPLETE, 8'h6F, 8'h6B};
                send_report(d, 5'(d.size()), 1'b0, 1'b0);
            end
        end
    endtask

    task automatic build_random_report(output t_ad_data d, output logic [4:0] rlen,
                                       output bit close_empty);
        int target;
        int room;
        int len;
        int pick;
        int k;
        bit stop;
        d      = {};
        stop   = 1'b0;
        target = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 31);
        while (d.size() < target) begin
            room = target - d.size();
            if (stop || room == 1) begin
                d.insert(d.size(), 8'($urandom_range(255)));
            end else begin
                len  = ($urandom_range(3) == 0) ? room - 1
                                                : $urandom_range(1, (room - 1 < 8) ? room - 1 : 8);
                pick = $urandom_range(99);
                if (pick < 8) begin
                    d.insert(d.size(), 8'h00);
                    stop = 1'b1;
                end else begin
                    d.insert(d.size(), 8'(len));
                    if (pick < 35)
                        d.insert(d.size(), $urandom_range(1) ? bleadv_pkg::TYPE_NAME_COMPLETE
                                                             : bleadv_pkg::TYPE_NAME_SHORT);
                    else if (pick < 65)
                        d.insert(d.size(), bleadv_pkg::TYPE_FLAGS);
                    else
                        d.insert(d.size(), 8'($urandom_range(255)));
                    for (k = 1; k < len; k++) d.insert(d.size(), 8'($urandom_range(255)));
                end
            end
        end
        rlen = 5'(d.size());
        pick = $urandom_range(99);
        if (pick < 8) begin
            rlen = 5'($urandom_range(31));
        end else if (pick < 16 && d.size() > 1) begin
            repeat ($urandom_range(1, d.size() - 1)) d.delete(d.size() - 1);
        end else if (pick < 22) begin
            repeat ($urandom_range(1, 3)) d.insert(d.size(), 8'($urandom_range(255)));
        end
        close_empty = ($urandom_range(9) == 0);
    endtask

    task automatic test_random_reports();
        t_ad_data   d;
        logic [4:0] rlen;
        bit         close_empty;
        int         phase_no;
        int         start;
        for (phase_no = 0; phase_no < 6; phase_no++) begin
            write_mode((phase_no == 0) ? bleadv_pkg::MODE_GENERAL : 2'($urandom_range(3)));
            quiet = (phase_no == 2);
            start = items_sent;
            while (items_sent - start < 80) begin
                build_random_report(d, rlen, close_empty);
                send_report(d, rlen, close_empty, $urandom_range(19) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_parse_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (name_and_verdict_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = name_and_verdict_q.pop_front();
                cmp_field("result_kind", 8'(o_result_kind), 8'(want.kind));
                cmp_field("name_byte", o_name_byte, want.nbyte);
                cmp_field("name_last", 8'(o_name_last), 8'(want.nlast));
                cmp_field("name_found", 8'(o_name_found), 8'(want.found));
                cmp_field("name_length", 8'(o_name_length), 8'(want.nlen));
                cmp_field("flags_found", 8'(o_flags_found), 8'(want.flags_found));
                cmp_field("flags_value", o_flags_value, want.flags_value);
                cmp_field("report_accepted", 8'(o_report_accepted), 8'(want.accepted));
                cmp_field("parse_status", 8'(o_parse_status), 8'(want.status));
                cmp_field("device_found", 8'(o_device_found), 8'(want.device));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(99) < 20) begin
            stall_left = gap_len() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_valid         = 1'b0;
        i_ad_byte       = '0;
        i_has_byte      = 1'b0;
        i_report_length = '0;
        i_report_last   = 1'b0;
        clear_report();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_report();
        test_flags_then_name();
        test_walk_stops();
        test_empty_fields();
        test_truncated_report();
        test_bytes_past_report();
        test_discovery_modes();
        test_random_reports();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
